// ----- src/mfp_pkg.sv -----
// Shared types and constants of the msgpack frame parser.
// Used by every module of the block but mfp_in_stage; depends on nothing.
`default_nettype none

package mfp_pkg;

  // Stream markers.
  localparam logic [7:0] MARK_ARRAY3 = 8'h93;
  localparam logic [7:0] MARK_UINT8  = 8'hCC;
  localparam logic [7:0] MARK_BIN8   = 8'hC4;
  localparam logic [7:0] MARK_BIN16  = 8'hC5;
  localparam logic [7:0] MARK_BIN32  = 8'hC6;
  localparam logic [7:0] FIXINT_MAX  = 8'h7F;

  // Configuration register indexes.
  localparam logic CFG_TYPE_MIN = 1'b0;
  localparam logic CFG_TYPE_MAX = 1'b1;

  localparam logic [7:0] TYPE_MIN_RESET = 8'd0;
  localparam logic [7:0] TYPE_MAX_RESET = 8'd3;

  typedef enum logic [3:0] {
    PH_WAIT      = 4'd0,
    PH_TYPE      = 4'd1,
    PH_TYPE_U8   = 4'd2,
    PH_METH_MARK = 4'd3,
    PH_METH_LEN  = 4'd4,
    PH_METH_DATA = 4'd5,
    PH_PAY_MARK  = 4'd6,
    PH_PAY_LEN   = 4'd7,
    PH_PAY_DATA  = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TYPE      = 3'd0,
    KIND_METHOD    = 3'd1,
    KIND_PAYLOAD   = 3'd2,
    KIND_EMPTY_END = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_ARRAY_MARK = 2'd0,
    ERR_TYPE_ENC   = 2'd1,
    ERR_TYPE_RANGE = 2'd2,
    ERR_BIN_MARK   = 2'd3
  } err_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] field_remaining;
    logic [2:0]  length_bytes_left;
    logic [33:0] frame_byte_count;
  } parse_state_t;

  typedef struct packed {
    logic        has;
    kind_t       kind;
    logic [7:0]  value;
    err_t        error_code;
    logic        last;
    logic [33:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

// ----- src/msgpack_frame_parser.sv -----
// Top level of the msgpack frame parser: registers, state and handshakes.
// Depends on mfp_pkg, mfp_in_stage, mfp_step and mfp_out_stage.
//
// Usage: the input channel (in_valid, in_ready, data_byte) carries one word of
// the raw msgpack stream per handshake. Frames are fixarray-3, a message type,
// then a method bin field and a payload bin field. The output channel (out_valid,
// out_ready, kind, value, error_code, last, frame_length) carries at most one
// result word per input word: the type, each method byte, each payload byte, an
// end word for an empty payload, or an error with the offending word. The word
// that completes a frame has last set and the frame length in words.
// Throughput is one word per clock unless a full result register holds one back.
// A word is registered in the input register, stepped through the parse logic
// and, if it yields a result, lands in the result register behind out_valid.
// While the result register is full and not taken, a held word that yields a
// result waits and blocks the input; a held word that yields nothing (markers,
// length words) is still stepped, so such words keep moving.
// Reset returns the parser to waiting for an array marker and sets the type
// range to 0..3. Configuration writes take effect at the edge where cfg_write
// is high and should be made only while no word is in flight.
`default_nettype none

module msgpack_frame_parser
  import mfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [7:0]       value,
  output logic [1:0]       error_code,
  output logic             last,
  output logic [33:0]      frame_length,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic         hold_valid;
  logic [7:0]   hold_byte;
  logic         advance;
  logic         slot_free;
  logic [7:0]   type_min;
  logic [7:0]   type_max;
  parse_state_t state;
  parse_state_t state_next;
  result_t      step_res;
  result_t      res_out;

  // The held word is stepped when its result, if any, has a place to go.
  assign advance = hold_valid && (!step_res.has || slot_free);

  mfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .data_byte  (data_byte),
    .advance    (advance),
    .in_ready   (in_ready),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  mfp_step u_step (
    .cur      (state),
    .data     (hold_byte),
    .type_min (type_min),
    .type_max (type_max),
    .nxt      (state_next),
    .res      (step_res)
  );

  mfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && step_res.has),
    .res_in    (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .res_out   (res_out)
  );

  // Frame state only moves when a word is actually stepped.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase             <= PH_WAIT;
      state.field_remaining   <= '0;
      state.length_bytes_left <= '0;
      state.frame_byte_count  <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_min <= TYPE_MIN_RESET;
      type_max <= TYPE_MAX_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_TYPE_MIN) begin
        type_min <= cfg_data;
      end else begin
        type_max <= cfg_data;
      end
    end
  end

  assign kind         = res_out.kind;
  assign value        = res_out.value;
  assign error_code   = res_out.error_code;
  assign last         = res_out.last;
  assign frame_length = res_out.frame_length;

`ifndef NO_ASSERTIONS
  // Only payload data or an empty-payload end may close a frame.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (res_out.kind == KIND_PAYLOAD || res_out.kind == KIND_EMPTY_END))
    else $error("last set on a word that cannot close a frame");

  // Errors never close a frame and carry no length.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_out.kind == KIND_ERROR |-> !last && frame_length == 34'd0)
    else $error("error word carries frame end information");

  // Data phases are entered only with a nonzero byte count.
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_METH_DATA || state.phase == PH_PAY_DATA)
      |-> state.field_remaining != 32'd0)
    else $error("data phase with no bytes left");

  // Length phases always have between one and four length words pending.
  a_len_count: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_METH_LEN || state.phase == PH_PAY_LEN)
      |-> state.length_bytes_left != 3'd0 && state.length_bytes_left <= 3'd4)
    else $error("length phase with bad length word count");

  // A word that produced a result must be visible on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    advance && step_res.has |=> out_valid)
    else $error("stepped result not presented");
`endif

endmodule

`default_nettype wire

// ----- src/mfp_in_stage.sv -----
// Input register of the msgpack frame parser: holds one stream word.
// Depends on nothing but the clock and reset.
`default_nettype none

module mfp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] data_byte,
  input  wire logic       advance,
  output logic            in_ready,
  output logic            hold_valid,
  output logic [7:0]      hold_byte
);

  // The held word leaves when the parser steps on it; a new one may enter at once.
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= data_byte;
    end
  end

endmodule

`default_nettype wire

// ----- src/mfp_step.sv -----
// Combinational parse step: one stream word against the current frame state.
// Depends on mfp_pkg.
`default_nettype none

module mfp_step
  import mfp_pkg::*;
(
  input  wire parse_state_t cur,
  input  wire logic [7:0]   data,
  input  wire logic [7:0]   type_min,
  input  wire logic [7:0]   type_max,
  output parse_state_t      nxt,
  output result_t           res
);

  logic        err;
  err_t        err_code;
  logic        type_ok;
  logic [31:0] len_shifted;
  logic [31:0] remain_dec;
  logic [2:0]  left_dec;
  logic [2:0]  bin_len_bytes;
  logic        bin_ok;

  assign type_ok     = (data >= type_min) && (data <= type_max);
  assign len_shifted = {cur.field_remaining[23:0], data};
  assign remain_dec  = cur.field_remaining - 32'd1;
  assign left_dec    = cur.length_bytes_left - 3'd1;

  always_comb begin
    bin_ok        = 1'b1;
    bin_len_bytes = 3'd0;
    case (data)
      MARK_BIN8:  bin_len_bytes = 3'd1;
      MARK_BIN16: bin_len_bytes = 3'd2;
      MARK_BIN32: bin_len_bytes = 3'd4;
      default:    bin_ok = 1'b0;
    endcase
  end

  always_comb begin
    nxt                  = cur;
    nxt.frame_byte_count = cur.frame_byte_count + 34'd1;
    res                  = '0;
    err                  = 1'b0;
    err_code             = ERR_ARRAY_MARK;

    unique case (cur.phase)
      PH_TYPE, PH_TYPE_U8: begin
        if (cur.phase == PH_TYPE && data > FIXINT_MAX) begin
          if (data == MARK_UINT8) begin
            nxt.phase = PH_TYPE_U8;
          end else begin
            err      = 1'b1;
            err_code = ERR_TYPE_ENC;
          end
        end else if (!type_ok) begin
          err      = 1'b1;
          err_code = ERR_TYPE_RANGE;
        end else begin
          nxt.phase = PH_METH_MARK;
          res.has   = 1'b1;
          res.kind  = KIND_TYPE;
          res.value = data;
        end
      end
      PH_METH_MARK, PH_PAY_MARK: begin
        if (bin_ok) begin
          nxt.field_remaining   = '0;
          nxt.length_bytes_left = bin_len_bytes;
          nxt.phase = (cur.phase == PH_METH_MARK) ? PH_METH_LEN : PH_PAY_LEN;
        end else begin
          err      = 1'b1;
          err_code = ERR_BIN_MARK;
        end
      end
      PH_METH_LEN: begin
        nxt.field_remaining   = len_shifted;
        nxt.length_bytes_left = left_dec;
        if (left_dec == 3'd0) begin
          // A zero-length method goes straight on to the payload marker.
          nxt.phase = (len_shifted != 32'd0) ? PH_METH_DATA : PH_PAY_MARK;
        end
      end
      PH_METH_DATA: begin
        nxt.field_remaining = remain_dec;
        if (remain_dec == 32'd0) begin
          nxt.phase = PH_PAY_MARK;
        end
        res.has   = 1'b1;
        res.kind  = KIND_METHOD;
        res.value = data;
      end
      PH_PAY_LEN: begin
        nxt.field_remaining   = len_shifted;
        nxt.length_bytes_left = left_dec;
        if (left_dec == 3'd0) begin
          if (len_shifted != 32'd0) begin
            nxt.phase = PH_PAY_DATA;
          end else begin
            // An empty payload closes the frame on its last length word.
            nxt.phase        = PH_WAIT;
            res.has          = 1'b1;
            res.kind         = KIND_EMPTY_END;
            res.last         = 1'b1;
            res.frame_length = nxt.frame_byte_count;
          end
        end
      end
      PH_PAY_DATA: begin
        nxt.field_remaining = remain_dec;
        res.has   = 1'b1;
        res.kind  = KIND_PAYLOAD;
        res.value = data;
        if (remain_dec == 32'd0) begin
          nxt.phase        = PH_WAIT;
          res.last         = 1'b1;
          res.frame_length = nxt.frame_byte_count;
        end
      end
      default: begin
        if (data == MARK_ARRAY3) begin
          nxt.frame_byte_count  = 34'd1;
          nxt.field_remaining   = '0;
          nxt.length_bytes_left = '0;
          nxt.phase             = PH_TYPE;
        end else begin
          err      = 1'b1;
          err_code = ERR_ARRAY_MARK;
        end
      end
    endcase

    if (err) begin
      nxt.phase             = PH_WAIT;
      nxt.field_remaining   = '0;
      nxt.length_bytes_left = '0;
      nxt.frame_byte_count  = '0;
      res                   = '0;
      res.has               = 1'b1;
      res.kind              = KIND_ERROR;
      res.value             = data;
      res.error_code        = err_code;
    end
  end

endmodule

`default_nettype wire

// ----- src/mfp_out_stage.sv -----
// Result register of the msgpack frame parser, held until the receiver takes it.
// Depends on mfp_pkg.
`default_nettype none

module mfp_out_stage
  import mfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  input  wire logic    out_ready,
  output logic         out_valid,
  output logic         slot_free,
  output result_t      res_out
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// ----- tb/mfp_checker.sv -----
// Checker for the msgpack frame parser: watches both word channels and the
// configuration port, predicts every result word and compares it field by field.
// Depends on mfp_pkg for the phase, kind and error types and the stream markers.
`default_nettype none

module mfp_checker
  import mfp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_ready,
  input  wire logic [7:0]   data_byte,
  input  wire logic         out_valid,
  input  wire logic         out_ready,
  input  wire logic [2:0]   kind,
  input  wire logic [7:0]   value,
  input  wire logic [1:0]   error_code,
  input  wire logic         last,
  input  wire logic [33:0]  frame_length,
  input  wire logic         cfg_write,
  input  wire logic         cfg_index,
  input  wire logic [7:0]   cfg_data,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Error code field carried by every word that is not an error.
  localparam err_t NO_ERROR = ERR_ARRAY_MARK;

  logic [7:0]  lo_type;
  logic [7:0]  hi_type;
  phase_t      ph;
  logic [31:0] field_left;
  logic [2:0]  len_bytes_left;
  logic [33:0] frame_bytes;
  result_t     pending_words[$];

  function automatic result_t make_word(kind_t k, logic [7:0] v, err_t e, logic fin,
                                        logic [33:0] flen);
    result_t r;
    r.has = 1'b1;
    r.kind = k;
    r.value = v;
    r.error_code = e;
    r.last = fin;
    r.frame_length = fin ? flen : '0;
    return r;
  endfunction

  // Any error drops the frame and sends the parser back to hunting for 0x93.
  function automatic result_t drop_frame(err_t e, logic [7:0] b);
    ph = PH_WAIT;
    field_left = '0;
    len_bytes_left = '0;
    frame_bytes = '0;
    return make_word(KIND_ERROR, b, e, 1'b0, '0);
  endfunction

  function automatic logic open_bin(logic [7:0] b);
    field_left = '0;
    case (b)
      MARK_BIN8:  len_bytes_left = 3'd1;
      MARK_BIN16: len_bytes_left = 3'd2;
      MARK_BIN32: len_bytes_left = 3'd4;
      default:    return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic result_t take_type(logic [7:0] t);
    if (t < lo_type || t > hi_type) return drop_frame(ERR_TYPE_RANGE, t);
    ph = PH_METH_MARK;
    return make_word(KIND_TYPE, t, NO_ERROR, 1'b0, '0);
  endfunction

  // Advances the predicted parser by one stream byte; has is clear when the
  // byte yields no result word.
  function automatic result_t parse_word(logic [7:0] b);
    result_t none;
    none = '0;
    frame_bytes = frame_bytes + 34'd1;
    case (ph)
      PH_TYPE: begin
        if (b <= FIXINT_MAX) return take_type(b);
        if (b == MARK_UINT8) begin
          ph = PH_TYPE_U8;
          return none;
        end
        return drop_frame(ERR_TYPE_ENC, b);
      end
      PH_TYPE_U8: return take_type(b);
      PH_METH_MARK, PH_PAY_MARK: begin
        if (!open_bin(b)) return drop_frame(ERR_BIN_MARK, b);
        ph = (ph == PH_METH_MARK) ? PH_METH_LEN : PH_PAY_LEN;
        return none;
      end
      PH_METH_LEN, PH_PAY_LEN: begin
        field_left = {field_left[23:0], b};
        len_bytes_left = len_bytes_left - 3'd1;
        if (len_bytes_left != 3'd0) return none;
        if (field_left != 32'd0) begin
          ph = (ph == PH_METH_LEN) ? PH_METH_DATA : PH_PAY_DATA;
          return none;
        end
        // An empty method emits nothing; an empty payload closes the frame.
        if (ph == PH_METH_LEN) begin
          ph = PH_PAY_MARK;
          return none;
        end
        ph = PH_WAIT;
        return make_word(KIND_EMPTY_END, 8'h00, NO_ERROR, 1'b1, frame_bytes);
      end
      PH_METH_DATA: begin
        field_left = field_left - 32'd1;
        if (field_left == 32'd0) ph = PH_PAY_MARK;
        return make_word(KIND_METHOD, b, NO_ERROR, 1'b0, '0);
      end
      PH_PAY_DATA: begin
        field_left = field_left - 32'd1;
        if (field_left == 32'd0) begin
          ph = PH_WAIT;
          return make_word(KIND_PAYLOAD, b, NO_ERROR, 1'b1, frame_bytes);
        end
        return make_word(KIND_PAYLOAD, b, NO_ERROR, 1'b0, '0);
      end
      default: begin
        if (b != MARK_ARRAY3) return drop_frame(ERR_ARRAY_MARK, b);
        frame_bytes = 34'd1;
        field_left = '0;
        len_bytes_left = '0;
        ph = PH_TYPE;
        return none;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [33:0] want, logic [33:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t produced;
    if (rst) begin
      lo_type = TYPE_MIN_RESET;
      hi_type = TYPE_MAX_RESET;
      ph = PH_WAIT;
      field_left = '0;
      len_bytes_left = '0;
      frame_bytes = '0;
      pending_words.delete();
    end else begin
      // Results are compared before this edge's input is predicted, so a word
      // that shows up with nothing waiting is always flagged.
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected result word: kind %0d value %0d", kind, value);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          check_field("kind", 34'(want.kind), 34'(kind));
          check_field("value", 34'(want.value), 34'(value));
          check_field("error_code", 34'(want.error_code), 34'(error_code));
          check_field("last", 34'(want.last), 34'(last));
          check_field("frame_length", want.frame_length, frame_length);
        end
      end
      if (in_valid && in_ready) begin
        produced = parse_word(data_byte);
        if (produced.has) pending_words.push_back(produced);
      end
      if (cfg_write) begin
        if (cfg_index == CFG_TYPE_MIN) lo_type = cfg_data;
        else hi_type = cfg_data;
      end
    end
    outstanding <= pending_words.size();
  end

endmodule

`default_nettype wire

// ----- tb/tb_msgpack_frame_parser.sv -----
// Testbench top for the msgpack frame parser: clock, reset, stimulus and verdict.
// Depends on mfp_pkg, the msgpack_frame_parser RTL and the mfp_checker module.
`default_nettype none

module tb_msgpack_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import mfp_pkg::*;

  // The run is far shorter than this even with both sides idling heavily;
  // hitting it means the block stopped moving words.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Quiet time after the last result, enough for a word that yields nothing
  // to clear the two-stage pipeline before the next register write.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned WORDS_PER_PHASE = 205;
  localparam int unsigned NUM_PHASES = 5;

  // Type range per phase: the reset range, the full range, the top value only,
  // a single mid value, and an inverted range that rejects every type.
  localparam logic [7:0] LO_SET [NUM_PHASES] = '{8'd0, 8'd0, 8'd255, 8'd7, 8'd128};
  localparam logic [7:0] HI_SET [NUM_PHASES] = '{8'd3, 8'd255, 8'd255, 8'd7, 8'd5};
  // Idle percentages, cycled over the phases: none, sender only, receiver only, both.
  localparam int unsigned SEND_IDLE [4] = '{0, 85, 0, 30};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 85, 30};

  // Ways a random frame may be broken.
  localparam int unsigned FLAW_NONE       = 0;
  localparam int unsigned FLAW_NOISE      = 1;
  localparam int unsigned FLAW_TYPE_ENC   = 2;
  localparam int unsigned FLAW_TYPE_RANGE = 3;
  localparam int unsigned FLAW_METH_MARK  = 4;
  localparam int unsigned FLAW_PAY_MARK   = 5;
  localparam int unsigned FLAW_TRUNCATE   = 6;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  value;
  logic [1:0]  error_code;
  logic        last;
  logic [33:0] frame_length;
  logic        cfg_write;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic [7:0]  cur_lo = TYPE_MIN_RESET;
  logic [7:0]  cur_hi = TYPE_MAX_RESET;

  always #2 clk = ~clk;

  msgpack_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .value(value),
    .error_code(error_code),
    .last(last),
    .frame_length(frame_length),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  mfp_checker u_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .value(value),
    .error_code(error_code),
    .last(last),
    .frame_length(frame_length),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // The receiver redraws its ready at every falling edge, so stalls land on
  // every stage of a frame, including words that carry the last flag.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_msgpack_frame_parser: done, errors");
      $finish;
    end
  end

  // Offers one word and returns at the falling edge after it is taken. Valid
  // is left high so that back-to-back words keep the channel busy; the next
  // call decides whether to idle first.
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Waits until every predicted word has come back, then lets the pipeline
  // run dry of words that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes both type bounds on consecutive edges; call only while idle.
  task automatic set_range(input logic [7:0] lo, input logic [7:0] hi);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TYPE_MIN;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= CFG_TYPE_MAX;
    cfg_data <= hi;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // Mostly short fields, now and then a longer one.
  function automatic int unsigned pick_length();
    return ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
  endfunction

  // Sends one bin field with a random length encoding. A bad marker ends the
  // field at once; a nonzero cut leaves that many data words unsent, so the
  // next frame's opening words get swallowed as data.
  task automatic send_bin(input int unsigned len, input bit bad_mark,
                          input int unsigned cut);
    logic [7:0]  b;
    logic [31:0] len_word;
    int unsigned width;
    len_word = len;
    if (bad_mark) begin
      do b = 8'($urandom); while (b >= MARK_BIN8 && b <= MARK_BIN32);
      send_word(b);
      return;
    end
    case ($urandom_range(2))
      0: begin
        b = MARK_BIN8;
        width = 1;
      end
      1: begin
        b = MARK_BIN16;
        width = 2;
      end
      default: begin
        b = MARK_BIN32;
        width = 4;
      end
    endcase
    send_word(b);
    for (int i = width - 1; i >= 0; i--) send_word(len_word[8*i +: 8]);
    repeat (len - cut) send_word(8'($urandom));
  endtask

  // One random frame: most are well formed with random content, the rest
  // carry one flaw each.
  task automatic send_frame();
    logic [7:0]  b;
    logic [7:0]  t;
    int unsigned flaw;
    int unsigned pay_len;
    int unsigned cut;
    flaw = ($urandom_range(99) < 80) ? FLAW_NONE : $urandom_range(FLAW_TRUNCATE, FLAW_NOISE);

    // Noise never holds an array marker, so it cannot open a stray frame
    // whose length bytes would be random.
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(4, 1)) begin
        do b = 8'($urandom); while (b == MARK_ARRAY3);
        send_word(b);
      end
    end
    send_word(MARK_ARRAY3);

    if (flaw == FLAW_TYPE_ENC) begin
      do b = 8'($urandom_range(255, 128)); while (b == MARK_UINT8);
      send_word(b);
      return;
    end
    if (flaw == FLAW_TYPE_RANGE || cur_lo > cur_hi || $urandom_range(9) == 0)
      t = 8'($urandom);
    else
      t = 8'($urandom_range(cur_hi, cur_lo));
    // Small types go either as a positive fixint or behind the uint8 marker.
    if (t <= FIXINT_MAX && $urandom_range(1) == 1) begin
      send_word(t);
    end else begin
      send_word(MARK_UINT8);
      send_word(t);
    end
    // A rejected type drops the frame; the parser hunts for the next marker.
    if (t < cur_lo || t > cur_hi) return;

    send_bin(pick_length(), flaw == FLAW_METH_MARK, 0);
    if (flaw == FLAW_METH_MARK) return;
    pay_len = pick_length();
    if (flaw == FLAW_TRUNCATE && pay_len == 0) pay_len = 1;
    cut = (flaw == FLAW_TRUNCATE) ? $urandom_range(pay_len, 1) : 0;
    send_bin(pay_len, flaw == FLAW_PAY_MARK, cut);
  endtask

  initial begin
    logic [7:0]  opening[$];
    int unsigned phase_start;
    in_valid = 1'b0;
    data_byte = 8'h00;
    cfg_write = 1'b0;
    cfg_index = CFG_TYPE_MIN;
    cfg_data = 8'h00;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_range(TYPE_MIN_RESET, TYPE_MAX_RESET);

    opening = {
      // Fixint type, empty method, a one-word payload of all ones.
      MARK_ARRAY3, 8'h01, MARK_BIN8, 8'h00, MARK_BIN8, 8'h01, 8'hFF,
      // Type zero behind the uint8 marker, a bin16 method holding a zero word,
      // and an empty bin32 payload that closes the frame with an end word.
      MARK_ARRAY3, MARK_UINT8, 8'h00, MARK_BIN16, 8'h00, 8'h01, 8'h00,
      MARK_BIN32, 8'h00, 8'h00, 8'h00, 8'h00,
      // A stray word while hunting for a frame.
      8'h00,
      // A type word that is neither a fixint nor the uint8 marker.
      MARK_ARRAY3, 8'h80,
      // The largest uint8 type, outside the reset range.
      MARK_ARRAY3, MARK_UINT8, 8'hFF,
      // A method marker that is not a bin marker.
      MARK_ARRAY3, 8'h02, 8'hC7
    };
    foreach (opening[i]) send_word(opening[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_range(LO_SET[p], HI_SET[p]);
      send_idle_pct = SEND_IDLE[p % 4];
      stall_pct = RECV_STALL[p % 4];
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) send_frame();
    end
    settle();

    if (mismatches == 0 && outstanding == 0)
      $display("tb_msgpack_frame_parser: done, clean");
    else
      $display("tb_msgpack_frame_parser: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/mfp_pkg.sv
src/mfp_in_stage.sv
src/mfp_step.sv
src/mfp_out_stage.sv
src/msgpack_frame_parser.sv
tb/mfp_checker.sv
tb/tb_msgpack_frame_parser.sv
